/* hdl/lph_pkg.sv */
// Shared types and constants for the linear probing hash table.
package lph_pkg;

  localparam int KEY_W              = 31;
  localparam int DATA_W             = 32;
  localparam int USER_W             = 2;
  localparam int DEFAULT_TABLE_SIZE = 16;

  localparam logic [1:0] OP_FIND   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_REPLY
  } lph_state_t;

endpackage

/* hdl/lph_ram.sv */
// Generic simple dual port RAM with registered read.
module lph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/lph_rem.sv */
// Key remainder unit: mask for a power-of-two divisor, else a pipelined reciprocal multiply.
module lph_rem import lph_pkg::*; #(
  parameter int DIVISOR = DEFAULT_TABLE_SIZE
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [KEY_W-1:0]           dividend,
  output logic                       done,
  output logic [$clog2(DIVISOR)-1:0] rem
);

  localparam int  IDX_W   = $clog2(DIVISOR);
  localparam bit  POW2    = ((DIVISOR & (DIVISOR - 1)) == 0);
  localparam int  SHIFT   = KEY_W + IDX_W;
  localparam int  RECIP_W = KEY_W + 1;
  localparam int  PROD_W  = KEY_W + RECIP_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_FULL);
  localparam logic [IDX_W-1:0]   DIV_LO = IDX_W'(DIVISOR);

  logic              s1_r, s1_nxt;
  logic              s2_r, s2_nxt;
  logic              done_r, done_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [IDX_W-1:0]  key_lo_r, key_lo_nxt;
  logic [IDX_W-1:0]  qn_r, qn_nxt;
  logic [IDX_W-1:0]  rem_r, rem_nxt;
  logic [KEY_W-1:0]  quot;
  logic [IDX_W-1:0]  qn_lo;

  // quotient is exact for every 31-bit key; only its low bits are needed
  assign quot  = KEY_W'(prod_r >> SHIFT);
  assign qn_lo = quot[IDX_W-1:0] * DIV_LO;

  always_comb begin
    s1_nxt     = 1'b0;
    s2_nxt     = s1_r;
    done_nxt   = 1'b0;
    prod_nxt   = prod_r;
    key_lo_nxt = key_lo_r;
    qn_nxt     = qn_r;
    rem_nxt    = rem_r;
    if (start) begin
      key_lo_nxt = dividend[IDX_W-1:0];
      if (POW2) begin
        rem_nxt  = dividend[IDX_W-1:0];
        done_nxt = 1'b1;
      end else begin
        prod_nxt = PROD_W'(dividend) * PROD_W'(RECIP);
        s1_nxt   = 1'b1;
      end
    end
    if (s1_r) begin
      qn_nxt = qn_lo;
    end
    if (s2_r) begin
      rem_nxt  = key_lo_r - qn_r;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      done_r <= done_nxt;
    end
    prod_r   <= prod_nxt;
    key_lo_r <= key_lo_nxt;
    qn_r     <= qn_nxt;
    rem_r    <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* hdl/linear_probe_hash_table.sv */
// Linear probing hash table with lazy delete: top level.
// One command at a time. After reset the table is swept clear, bucket by bucket, with
// in_tready low. A command with key zero or an unused code goes straight to the reply.
// Otherwise the home bucket (key mod TABLE_SIZE) is taken by a mask when TABLE_SIZE is a
// power of two and by a reciprocal multiply otherwise; then the single table read port
// probes one bucket per cycle, up to TABLE_SIZE buckets, and the reply state posts the
// result once the output register is free. The result sits in that register until taken.
module linear_probe_hash_table import lph_pkg::*; #(
  parameter int TABLE_SIZE = DEFAULT_TABLE_SIZE
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [30:0] item_key, [31] zero
  input  logic [USER_W-1:0] in_tuser,   // [1:0] operation
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [30:0] found_key, [31] zero
  output logic [USER_W-1:0] out_tuser   // [1:0] status
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int WORD_W = KEY_W + 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIZE - 1);

  lph_state_t state_r, state_nxt;

  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]  step_r, step_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [KEY_W-1:0]  res_key_r, res_key_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [KEY_W-1:0]  out_key_r, out_key_nxt;

  logic              in_xfer;
  logic              in_bad;
  logic              slot_free;
  logic              rem_start;
  logic              rem_done;
  logic [IDX_W-1:0]  home;
  logic [IDX_W-1:0]  nxt_bucket;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [KEY_W-1:0]  rd_key;
  logic              rd_act;
  logic              empty, match, free, last;
  logic              probe_done;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign in_bad     = (in_tdata[KEY_W-1:0] == '0) ||
                      !(in_tuser == OP_FIND || in_tuser == OP_INSERT ||
                        in_tuser == OP_REMOVE);
  assign slot_free  = !out_valid_r || out_tready;
  assign nxt_bucket = (cur_r == LAST) ? '0 : cur_r + 1'b1;

  assign rd_key = ram_rdata[KEY_W-1:0];
  assign rd_act = ram_rdata[KEY_W];
  assign empty  = (rd_key == '0);
  assign match  = rd_act && (rd_key == key_r);
  assign free   = empty || !rd_act;
  assign last   = (step_r == LAST);
  assign probe_done = (op_r == OP_INSERT) ? (free || last) : (empty || match || last);

  lph_rem #(
    .DIVISOR (TABLE_SIZE)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (in_tdata[KEY_W-1:0]),
    .done     (rem_done),
    .rem      (home)
  );

  lph_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (cur_r == LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) state_nxt = in_bad ? S_REPLY : S_HASH;
      end
      S_HASH: begin
        if (rem_done) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (probe_done) state_nxt = S_REPLY;
      end
      S_REPLY: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cur_nxt        = cur_r;
    step_nxt       = step_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    rem_start      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = cur_r;
    ram_wdata      = '0;
    ram_raddr      = (state_r == S_HASH) ? home : nxt_bucket;
    case (state_r)
      S_CLEAR: begin
        ram_we  = 1'b1;
        cur_nxt = nxt_bucket;
      end
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt  = in_tuser;
          key_nxt = in_tdata[KEY_W-1:0];
          if (in_bad) begin
            res_status_nxt = ST_MISS;
            res_key_nxt    = '0;
          end else begin
            rem_start = 1'b1;
          end
        end
      end
      S_HASH: begin
        if (rem_done) begin
          cur_nxt  = home;
          step_nxt = '0;
        end
      end
      S_PROBE: begin
        if (probe_done) begin
          res_status_nxt = ST_MISS;
          res_key_nxt    = '0;
          case (op_r)
            OP_INSERT: begin
              if (free) begin
                ram_we         = 1'b1;
                ram_wdata      = {1'b1, key_r};
                res_status_nxt = ST_OK;
              end else begin
                res_status_nxt = ST_FULL;
              end
            end
            OP_FIND: begin
              if (match) begin
                res_status_nxt = ST_OK;
                res_key_nxt    = key_r;
              end
            end
            OP_REMOVE: begin
              if (match) begin
                ram_we         = 1'b1;
                ram_wdata      = {1'b0, rd_key};
                res_status_nxt = ST_OK;
                res_key_nxt    = rd_key;
              end
            end
            default: res_status_nxt = ST_MISS;
          endcase
        end else begin
          cur_nxt  = nxt_bucket;
          step_nxt = step_r + 1'b1;
        end
      end
      S_REPLY: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = res_key_r;
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r       <= step_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(DATA_W - KEY_W){1'b0}}, out_key_r};
  assign out_tuser  = out_status_r;

endmodule

/* hdl/lph_chk.sv */
// Port-level checker for the hash table, bound to the top level.
module lph_chk import lph_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [DATA_W-1:0] in_tdata,
  input logic [USER_W-1:0] in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata,
  input logic [USER_W-1:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_MISS || out_tuser == ST_FULL))
    else $error("unknown status code");

  a_miss_no_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_MISS || out_tuser == ST_FULL) |-> out_tdata == '0)
    else $error("key reported without a hit");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted while busy");

  a_clear_after_rst: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("command taken before table clear");

endmodule

bind linear_probe_hash_table lph_chk u_lph_chk (.*);

/* verif/linear_probe_hash_table_tb.sv */
// Testbench for linear_probe_hash_table: directed and random commands checked against a table model.
`timescale 1ns / 100ps

module linear_probe_hash_table_tb;
  import lph_pkg::*;

  localparam int TBL         = DEFAULT_TABLE_SIZE;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;
  localparam int POOL_N      = 24;

  typedef struct packed {
    logic             settle;
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
  } command_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] found_key;
  } reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic [USER_W-1:0] in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic [USER_W-1:0] out_tuser;

  logic [KEY_W-1:0] bucket_key [TBL];
  logic             bucket_live [TBL];
  logic [KEY_W-1:0] key_pool [POOL_N];

  command_t cmd_q[$];
  reply_t   awaited_replies[$];

  int send_idle_pct = 25;
  int recv_idle_pct = 71;
  int holds_asked = 0;
  int holds_granted = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int n_accepted = 0;
  int n_replies = 0;
  int n_ok = 0;
  int n_miss = 0;
  int n_full = 0;
  int n_tomb_reuse = 0;
  int mismatches = 0;

  linear_probe_hash_table #(.TABLE_SIZE(TBL)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #10 clk = ~clk;

  // Updates the table copy for one command and returns the reply it should produce.
  function automatic reply_t table_apply(input logic [1:0] op, input logic [KEY_W-1:0] key);
    reply_t r;
    int home;
    int b;
    int hit;
    r.status    = ST_MISS;
    r.found_key = '0;
    hit         = -1;
    if (key == '0) return r;
    home = int'(key % TBL);
    if (op == OP_FIND || op == OP_REMOVE) begin
      for (int s = 0; s < TBL; s++) begin
        b = (home + s) % TBL;
        if (bucket_key[b] == '0) break;
        if (bucket_live[b] && bucket_key[b] == key) begin
          hit = b;
          break;
        end
      end
      if (hit >= 0) begin
        r.status    = ST_OK;
        r.found_key = bucket_key[hit];
        if (op == OP_REMOVE) bucket_live[hit] = 1'b0;
      end
    end else if (op == OP_INSERT) begin
      r.status = ST_FULL;
      for (int s = 0; s < TBL; s++) begin
        b = (home + s) % TBL;
        if (bucket_key[b] == '0 || !bucket_live[b]) begin
          if (bucket_key[b] != '0) n_tomb_reuse++;
          bucket_key[b]  = key;
          bucket_live[b] = 1'b1;
          r.status       = ST_OK;
          break;
        end
      end
    end
    return r;
  endfunction

  task automatic queue_cmd(input logic [1:0] op, input logic [KEY_W-1:0] key,
                           input logic settle = 1'b0);
    command_t c;
    c.settle = settle;
    c.op     = op;
    c.key    = key;
    cmd_q.push_back(c);
  endtask

  // Mostly keys from a clustered pool so finds and removes hit; some noise.
  task automatic queue_random(input int ins_pct, input int rem_pct, input logic settle = 1'b0);
    int r;
    logic [1:0] op;
    logic [KEY_W-1:0] key;
    r = $urandom_range(99);
    if (r < ins_pct) op = OP_INSERT;
    else if (r < ins_pct + rem_pct) op = OP_REMOVE;
    else op = OP_FIND;
    if ($urandom_range(99) < 2) op = OP_UNUSED;
    r = $urandom_range(99);
    if (r < 2) key = '0;
    else if (r < 85) key = key_pool[$urandom_range(POOL_N - 1)];
    else begin
      key = KEY_W'($urandom);
      if (key == '0) key = 'd1;
    end
    queue_cmd(op, key, settle);
  endtask

  task automatic queue_phase(input int count, input logic settle_first);
    for (int i = 0; i < count; i++) begin
      if ((i / 40) % 2 == 0) queue_random(65, 10, settle_first && i == 0);
      else queue_random(15, 50, 1'b0);
    end
  endtask

  task automatic wait_drained();
    while (cmd_q.size() != 0 || awaited_replies.size() != 0 || in_tvalid) @(posedge clk);
  endtask

  // Driver
  always @(posedge clk) begin
    command_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        awaited_replies.push_back(table_apply(in_tuser, in_tdata[KEY_W-1:0]));
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_q.size() != 0 && !(cmd_q[0].settle &&
            (awaited_replies.size() != 0 || in_tvalid)) &&
            $urandom_range(99) >= send_idle_pct) begin
          c = cmd_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {{(DATA_W - KEY_W){1'b0}}, c.key};
          in_tuser  <= c.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure, with a long hold whenever one is asked for
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (holds_granted != holds_asked) begin
      holds_granted <= holds_granted + 1;
      hold_left     <= LONG_HOLD;
      out_tready    <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_replies++;
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: reply with none pending, status=%0d key=%h", out_tuser, out_tdata);
      end else begin
        want = awaited_replies.pop_front();
        case (want.status)
          ST_OK:   n_ok++;
          ST_MISS: n_miss++;
          default: n_full++;
        endcase
        if (out_tuser !== want.status ||
            out_tdata !== {{(DATA_W - KEY_W){1'b0}}, want.found_key}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: reply %0d status exp %0d got %0d, key exp %h got %h",
                     n_replies, want.status, out_tuser, want.found_key, out_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout at cycle %0d, %0d replies pending", cycle_count,
               awaited_replies.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < TBL; i++) begin
      bucket_key[i]  = '0;
      bucket_live[i] = 1'b0;
    end
    for (int i = 0; i < POOL_N; i++) begin
      key_pool[i] = KEY_W'($urandom);
      if (i < 16) key_pool[i] = {key_pool[i][KEY_W-1:4], 4'($urandom_range(5))};
      if (key_pool[i] == '0) key_pool[i] = 'd3;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // collisions, duplicates, tombstones and refused commands
    queue_cmd(OP_FIND, 'd5);
    queue_cmd(OP_REMOVE, 'd5);
    queue_cmd(OP_INSERT, 'd1);
    queue_cmd(OP_INSERT, 'd17);
    queue_cmd(OP_INSERT, 31'h7FFFFFFF);
    queue_cmd(OP_INSERT, 'd1);
    queue_cmd(OP_FIND, 'd17);
    queue_cmd(OP_REMOVE, 'd1);
    queue_cmd(OP_FIND, 'd1);
    queue_cmd(OP_REMOVE, 'd1);
    queue_cmd(OP_FIND, 'd1);
    queue_cmd(OP_FIND, 'd17);
    queue_cmd(OP_INSERT, 'd33);
    queue_cmd(OP_FIND, 'd33);
    queue_cmd(OP_INSERT, '0);
    queue_cmd(OP_FIND, '0);
    queue_cmd(OP_REMOVE, '0);
    queue_cmd(OP_UNUSED, 'd17);
    queue_cmd(OP_FIND, 31'h7FFFFFFF);
    queue_cmd(OP_REMOVE, 31'h7FFFFFFF);
    queue_cmd(OP_INSERT, 31'h55555555);
    queue_cmd(OP_FIND, 31'h2AAAAAAA);
    queue_cmd(OP_FIND, 31'h55555555);
    wait_drained();

    send_idle_pct = 25;
    recv_idle_pct = 71;
    queue_phase(280, 1'b0);
    wait_drained();

    send_idle_pct = 71;
    recv_idle_pct = 25;
    queue_phase(140, 1'b1);
    queue_phase(140, 1'b1);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_phase(280, 1'b0);
    holds_asked = holds_asked + 1;
    wait_drained();

    repeat (2 * TBL + 8) @(posedge clk);
    $display("Covered %0d commands, %0d replies: %0d ok, %0d miss, %0d table full,",
             n_accepted, n_replies, n_ok, n_miss, n_full);
    $display("  %0d tombstone reuses; mismatches %0d", n_tomb_reuse, mismatches);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* linear_probe_hash_table.f */
hdl/lph_pkg.sv
hdl/lph_ram.sv
hdl/lph_rem.sv
hdl/linear_probe_hash_table.sv
hdl/lph_chk.sv
verif/linear_probe_hash_table_tb.sv
